// ===== hw/rtl/qae_pkg.sv =====
// Shared constants, widths and the CORDIC arctangent table for the quaternion angle block.
package qae_pkg;

  // Default and maximum number of CORDIC iterations
  localparam int CordicStepsDef = 16;
  localparam int MaxSteps       = 24;

  // Field widths
  localparam int QuatW = 16;
  localparam int AzW   = 15;
  localparam int ElW   = 16;

  // Intermediate widths: products/sums at scale 2^30, CORDIC datapath, angle accumulator
  localparam int ProdW = 32;
  localparam int SumW  = 34;
  localparam int MagW  = 30;
  localparam int RadW  = 62;
  localparam int RootW = 31;
  localparam int RemW  = 34;
  localparam int CordW = 37;
  localparam int AccW  = 35;

  // Square root: two setup stages then one stage per result bit
  localparam int SqrtBits = RootW;
  localparam int SqrtLat  = SqrtBits + 2;

  // Fixed-point constants
  localparam logic signed [SumW-1:0] OneQ30    = SumW'(64'sd1073741824);
  localparam logic signed [AccW-1:0] HalfPiQ30 = AccW'(64'sh6487ED51);
  localparam int HalfPiQ13 = 12868;
  localparam int PiQ13     = 25736;

  // Arctangent of 2^-i at scale 2^30, truncated toward zero
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:    r = 32'h3243F6A8;
      5'd1:    r = 32'h1DAC6705;
      5'd2:    r = 32'h0FADBAFC;
      5'd3:    r = 32'h07F56EA6;
      5'd4:    r = 32'h03FEAB76;
      5'd5:    r = 32'h01FFD55B;
      5'd6:    r = 32'h00FFFAAA;
      5'd7:    r = 32'h007FFF55;
      5'd8:    r = 32'h003FFFEA;
      5'd9:    r = 32'h001FFFFD;
      5'd10:   r = 32'h000FFFFF;
      5'd11:   r = 32'h0007FFFF;
      5'd12:   r = 32'h0003FFFF;
      5'd13:   r = 32'h0001FFFF;
      5'd14:   r = 32'h0000FFFF;
      5'd15:   r = 32'h00007FFF;
      5'd16:   r = 32'h00003FFF;
      5'd17:   r = 32'h00001FFF;
      5'd18:   r = 32'h00000FFF;
      5'd19:   r = 32'h000007FF;
      5'd20:   r = 32'h000003FF;
      5'd21:   r = 32'h000001FF;
      5'd22:   r = 32'h000000FF;
      5'd23:   r = 32'h0000007F;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/qae_products.sv =====
// Quaternion product stage and sum stage forming sin/cos terms at scale 2^30.
module qae_products import qae_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [QuatW-1:0] quat_x_i,
  input  logic signed [QuatW-1:0] quat_y_i,
  input  logic signed [QuatW-1:0] quat_z_i,
  input  logic signed [QuatW-1:0] quat_w_i,
  output logic                   valid_o,
  output logic signed [SumW-1:0] sinr_o,
  output logic signed [SumW-1:0] cosr_o,
  output logic signed [SumW-1:0] sinp_o
);

  logic                   vld1_q, vld2_q;
  logic signed [ProdW-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q;
  logic signed [SumW-1:0]  sinr_q, cosr_q, sinp_q;
  logic signed [SumW-1:0]  sinr_d, cosr_d, sinp_d;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  // Form the six products
  always_ff @(posedge clk_i) begin
    wx_q <= quat_w_i * quat_x_i;
    yz_q <= quat_y_i * quat_z_i;
    xx_q <= quat_x_i * quat_x_i;
    yy_q <= quat_y_i * quat_y_i;
    wy_q <= quat_w_i * quat_y_i;
    zx_q <= quat_z_i * quat_x_i;
  end

  // Combine products into the atan2 and asin operands
  always_comb begin
    sinr_d = (SumW'(wx_q) + SumW'(yz_q)) <<< 1;
    cosr_d = OneQ30 - ((SumW'(xx_q) + SumW'(yy_q)) <<< 1);
    sinp_d = (SumW'(wy_q) - SumW'(zx_q)) <<< 1;
  end

  always_ff @(posedge clk_i) begin
    sinr_q <= sinr_d;
    cosr_q <= cosr_d;
    sinp_q <= sinp_d;
  end

  assign valid_o = vld2_q;
  assign sinr_o  = sinr_q;
  assign cosr_o  = cosr_q;
  assign sinp_o  = sinp_q;

endmodule

// ===== hw/rtl/qae_isqrt.sv =====
// Saturation check and pipelined square root of 1 - sinp^2, one root bit per stage.
module qae_isqrt import qae_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [SumW-1:0] sinp_i,
  output logic                   valid_o,
  output logic [RootW-1:0]       root_o,
  output logic signed [SumW-1:0] sinp_o,
  output logic                   sat_o
);

  logic                   vld_a_q, vld_b_q;
  logic                   sat_a_q, sat_b_q;
  logic signed [SumW-1:0] sinp_a_q, sinp_b_q;
  logic [MagW-1:0]        mag_a_q;
  logic [RadW-1:0]        rad_b_q;
  logic                   sat_d;
  logic [MagW-1:0]        mag_d;
  logic [2*MagW-1:0]      sq;

  // Per-bit stage registers; index k holds the state entering bit step k
  logic                   vld_q  [0:SqrtBits];
  logic                   sat_q  [0:SqrtBits];
  logic signed [SumW-1:0] sinp_q [0:SqrtBits];
  logic [RadW-1:0]        v_q    [0:SqrtBits];
  logic [RemW-1:0]        rem_q  [0:SqrtBits];
  logic [RootW-1:0]       root_q [0:SqrtBits];

  // Flag sines at or beyond one and take the magnitude
  always_comb begin
    sat_d = (sinp_i >= SumW'(OneQ30)) || (sinp_i <= -OneQ30);
    if (sat_d) begin
      mag_d = '0;
    end else if (sinp_i[SumW-1]) begin
      mag_d = MagW'(-sinp_i);
    end else begin
      mag_d = sinp_i[MagW-1:0];
    end
  end

  assign sq = mag_a_q * mag_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
    end
  end

  // Hold magnitude, then the radicand 2^60 - sinp^2
  always_ff @(posedge clk_i) begin
    sat_a_q  <= sat_d;
    sinp_a_q <= sinp_i;
    mag_a_q  <= mag_d;
    sat_b_q  <= sat_a_q;
    sinp_b_q <= sinp_a_q;
    rad_b_q  <= (RadW'(1) << 60) - RadW'(sq);
  end

  always_comb begin
    vld_q[0]  = vld_b_q;
    sat_q[0]  = sat_b_q;
    sinp_q[0] = sinp_b_q;
    v_q[0]    = rad_b_q;
    rem_q[0]  = '0;
    root_q[0] = '0;
  end

  // Restoring square root: one result bit per stage
  for (genvar k = 0; k < SqrtBits; k++) begin : g_bit
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic             take;

    assign rem_sh = {rem_q[k][RemW-3:0], v_q[k][RadW-1 -: 2]};
    assign trial  = {1'b0, root_q[k], 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sat_q[k+1]  <= sat_q[k];
      sinp_q[k+1] <= sinp_q[k];
      v_q[k+1]    <= v_q[k] << 2;
      rem_q[k+1]  <= take ? (rem_sh - trial) : rem_sh;
      root_q[k+1] <= {root_q[k][RootW-2:0], take};
    end
  end

  assign valid_o = vld_q[SqrtBits];
  assign root_o  = root_q[SqrtBits];
  assign sinp_o  = sinp_q[SqrtBits];
  assign sat_o   = sat_q[SqrtBits];

endmodule

// ===== hw/rtl/qae_cordic.sv =====
// Pipelined vectoring CORDIC atan2 with quadrant pre-rotation, rounding to Q3.13 and clamping.
module qae_cordic import qae_pkg::*; #(
  parameter int STEPS = CordicStepsDef,
  parameter int LIM   = PiQ13,
  parameter int OW    = ElW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [CordW-1:0] y_i,
  input  logic signed [CordW-1:0] x_i,
  input  logic                    force_i,
  input  logic                    force_neg_i,
  output logic                    valid_o,
  output logic signed [OW-1:0]    angle_o
);

  localparam int RW = AccW - 17;
  localparam logic signed [RW-1:0] LimR = RW'(LIM);

  logic                    vld_q  [0:STEPS];
  logic signed [CordW-1:0] cx_q   [0:STEPS];
  logic signed [CordW-1:0] cy_q   [0:STEPS];
  logic signed [AccW-1:0]  acc_q  [0:STEPS];
  logic                    zero_q [0:STEPS];
  logic                    frc_q  [0:STEPS];
  logic                    fneg_q [0:STEPS];

  logic signed [CordW-1:0] cx_d, cy_d;
  logic signed [AccW-1:0]  acc_d;
  logic signed [AccW-1:0]  rsum;
  logic signed [RW-1:0]    rnd;
  logic signed [OW-1:0]    ang_d;
  logic                    vld_out_q;
  logic signed [OW-1:0]    ang_q;

  // Rotate the left half-plane into the right one
  always_comb begin
    cx_d  = x_i;
    cy_d  = y_i;
    acc_d = '0;
    if (x_i[CordW-1]) begin
      if (!y_i[CordW-1]) begin
        cx_d  = y_i;
        cy_d  = -x_i;
        acc_d = HalfPiQ30;
      end else begin
        cx_d  = -y_i;
        cy_d  = x_i;
        acc_d = -HalfPiQ30;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q[0]   <= cx_d;
    cy_q[0]   <= cy_d;
    acc_q[0]  <= acc_d;
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    frc_q[0]  <= force_i;
    fneg_q[0] <= force_neg_i;
  end

  // One micro-rotation per stage, driving y toward zero
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CordW-1:0] dx, dy;
    logic signed [AccW-1:0]  ang;

    assign dx  = cy_q[i] >>> i;
    assign dy  = cx_q[i] >>> i;
    assign ang = AccW'(atan_q30(5'(i)));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!cy_q[i][CordW-1]) begin
        cx_q[i+1]  <= cx_q[i] + dx;
        cy_q[i+1]  <= cy_q[i] - dy;
        acc_q[i+1] <= acc_q[i] + ang;
      end else begin
        cx_q[i+1]  <= cx_q[i] - dx;
        cy_q[i+1]  <= cy_q[i] + dy;
        acc_q[i+1] <= acc_q[i] - ang;
      end
      zero_q[i+1] <= zero_q[i];
      frc_q[i+1]  <= frc_q[i];
      fneg_q[i+1] <= fneg_q[i];
    end
  end

  // Round half up to Q3.13, clamp, then apply the forced and zero cases
  always_comb begin
    rsum = acc_q[STEPS] + AccW'(65536);
    rnd  = rsum[AccW-1:17];
    if (rnd > LimR) begin
      rnd = LimR;
    end else if (rnd < -LimR) begin
      rnd = -LimR;
    end
    if (frc_q[STEPS]) begin
      ang_d = fneg_q[STEPS] ? -OW'(LIM) : OW'(LIM);
    end else if (zero_q[STEPS]) begin
      ang_d = '0;
    end else begin
      ang_d = OW'(rnd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q <= ang_d;
  end

  assign valid_o = vld_out_q;
  assign angle_o = ang_q;

endmodule

// ===== hw/rtl/quaternion_to_azimuth_elevation.sv =====
// Top level: quaternion to azimuth (asin, Q2.13) and elevation (atan2, Q3.13) angles.
// Throughput: one item per cycle; busy_o stays low, the pipeline never stalls.
// Latency is set by the square-root pipeline (31 bit stages) and the CORDIC stages.
// Reset clears all valid bits at once; items in flight are dropped.
// Results appear on done_o for one cycle and cannot be held off by the receiver.
module quaternion_to_azimuth_elevation import qae_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [QuatW-1:0] quat_x_i,
  input  logic signed [QuatW-1:0] quat_y_i,
  input  logic signed [QuatW-1:0] quat_z_i,
  input  logic signed [QuatW-1:0] quat_w_i,
  output logic                    done_o,
  output logic signed [AzW-1:0]   azimuth_angle_o,
  output logic signed [ElW-1:0]   elevation_angle_o,
  output logic                    azimuth_saturated_o
);

  localparam int Steps = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
  localparam int Lat   = Steps + SqrtLat + 4;

  logic                   accept;
  logic                   prod_vld;
  logic signed [SumW-1:0] sinr, cosr, sinp;
  logic                   sq_vld, sq_sat;
  logic [RootW-1:0]       sq_root;
  logic signed [SumW-1:0] sq_sinp;
  logic signed [SumW-1:0] sinr_dly_q [0:SqrtLat-1];
  logic signed [SumW-1:0] cosr_dly_q [0:SqrtLat-1];
  logic                   sat_dly_q  [0:Steps+1];
  logic                   az_vld, el_vld;
  logic signed [AzW-1:0]  az_ang;
  logic signed [ElW-1:0]  el_ang;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  qae_products u_products (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .quat_w_i (quat_w_i),
    .valid_o  (prod_vld),
    .sinr_o   (sinr),
    .cosr_o   (cosr),
    .sinp_o   (sinp)
  );

  qae_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_vld),
    .sinp_i  (sinp),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .sinp_o  (sq_sinp),
    .sat_o   (sq_sat)
  );

  // Delay the elevation operands alongside the square root
  always_ff @(posedge clk_i) begin
    sinr_dly_q[0] <= sinr;
    cosr_dly_q[0] <= cosr;
    for (int k = 1; k < SqrtLat; k++) begin
      sinr_dly_q[k] <= sinr_dly_q[k-1];
      cosr_dly_q[k] <= cosr_dly_q[k-1];
    end
  end

  qae_cordic #(
    .STEPS (Steps),
    .LIM   (PiQ13),
    .OW    (ElW)
  ) u_cordic_el (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (sq_vld),
    .y_i         (CordW'(sinr_dly_q[SqrtLat-1])),
    .x_i         (CordW'(cosr_dly_q[SqrtLat-1])),
    .force_i     (1'b0),
    .force_neg_i (1'b0),
    .valid_o     (el_vld),
    .angle_o     (el_ang)
  );

  qae_cordic #(
    .STEPS (Steps),
    .LIM   (HalfPiQ13),
    .OW    (AzW)
  ) u_cordic_az (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (sq_vld),
    .y_i         (CordW'(sq_sinp)),
    .x_i         (CordW'({1'b0, sq_root})),
    .force_i     (sq_sat),
    .force_neg_i (sq_sinp[SumW-1]),
    .valid_o     (az_vld),
    .angle_o     (az_ang)
  );

  // Carry the saturation flag to the output
  always_ff @(posedge clk_i) begin
    sat_dly_q[0] <= sq_sat;
    for (int k = 1; k < Steps + 2; k++) begin
      sat_dly_q[k] <= sat_dly_q[k-1];
    end
  end

  assign done_o              = az_vld;
  assign azimuth_angle_o     = az_ang;
  assign elevation_angle_o   = el_ang;
  assign azimuth_saturated_o = sat_dly_q[Steps+1];

  // Both angle pipelines deliver in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni) az_vld == el_vld)
    else $error("angle pipelines out of step");

  // A saturated azimuth is exactly plus or minus pi/2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && azimuth_saturated_o |->
      (azimuth_angle_o == AzW'(HalfPiQ13)) || (azimuth_angle_o == -AzW'(HalfPiQ13)))
    else $error("saturated azimuth not at pi/2");

  // Elevation stays within plus or minus pi
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (elevation_angle_o <= ElW'(PiQ13)) && (elevation_angle_o >= -ElW'(PiQ13)))
    else $error("elevation out of range");

  // Every accepted item completes after the fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |-> ##Lat done_o)
    else $error("item lost in pipeline");

endmodule
